// ===== design/assert_macros.svh =====
// Assertion macros used by the sequencer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Overlapping implication checked outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication on the next clock edge, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bta_pkg.sv =====
// ----------------------------------------------------------------------------
// Block transfer address sequencer package
// Widths, sequencer states, shared adder request and list helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bta_pkg;

    localparam int NUM_REGS   = 16;
    localparam int REG_W      = $clog2(NUM_REGS);
    localparam int ADDR_W     = 32;
    localparam int CNT_W      = $clog2(NUM_REGS + 1);
    localparam int WORD_SHIFT = 2;

    localparam logic [REG_W-1:0]  PC_NUM     = REG_W'(NUM_REGS - 1);
    localparam logic [ADDR_W-1:0] ALIGN_MASK = ~ADDR_W'(32'b11);
    localparam logic [ADDR_W-1:0] WORD_STEP  = ADDR_W'(4);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WB,
        ST_INIT,
        ST_RUN,
        ST_EMPTY
    } t_state;

    // Request to the shared address adder
    typedef struct packed {
        logic              sub;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
    } t_alu_req;

    // Index of the lowest set bit, zero for an empty list
    function automatic logic [REG_W-1:0] lowest_set(input logic [NUM_REGS-1:0] list);
        logic [REG_W-1:0] idx;
        idx = '0;
        for (int k = NUM_REGS - 1; k >= 0; k--) begin
            if (list[k]) begin
                idx = REG_W'(k);
            end
        end
        return idx;
    endfunction

    // Bit order reversal of a register list
    function automatic logic [NUM_REGS-1:0] reverse_list(input logic [NUM_REGS-1:0] list);
        logic [NUM_REGS-1:0] rev;
        for (int k = 0; k < NUM_REGS; k++) begin
            rev[k] = list[NUM_REGS-1-k];
        end
        return rev;
    endfunction

endpackage

// ===== design/bta_alu.sv =====
// ----------------------------------------------------------------------------
// Shared address adder
// Single add/subtract unit used for writeback, first address and stepping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bta_alu (
    input  bta_pkg::t_alu_req              i_req,
    output logic [bta_pkg::ADDR_W-1:0]     o_sum
);
    import bta_pkg::*;

    // wraps modulo 2^32
    always_comb begin
        if (i_req.sub) begin
            o_sum = i_req.a - i_req.b;
        end else begin
            o_sum = i_req.a + i_req.b;
        end
    end

endmodule

// ===== design/block_transfer_address_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// Block transfer address sequencer core
// Expands one load/store-multiple request into per-register accesses.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low. The
//   block then works alone: the shared adder forms the writeback value, then
//   the first address of a non-empty list, then one result per listed
//   register is issued, lowest register first when ascending, highest first
//   when descending. Each result sits on the o_ ports for one cycle with
//   o_valid high and o_last marks the final one. An empty list gives one
//   result with o_access_valid low.
//   A new request is taken only once the sequencer is back in idle; the
//   single shared adder steps the address once per issued result.
//   Reset (synchronous, active low) returns the sequencer to idle and drops
//   o_valid. The receiver cannot stall: every result must be taken as shown.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_transfer_address_sequencer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_req_type,
    input  logic [bta_pkg::ADDR_W-1:0]        i_base_value,
    input  logic [bta_pkg::REG_W-1:0]         i_base_index,
    input  logic [bta_pkg::NUM_REGS-1:0]      i_register_list,
    input  logic                              i_increment,
    input  logic                              i_before_req,
    input  logic                              i_writeback,
    input  logic                              i_user_bank,
    output logic                              o_valid,
    output logic [bta_pkg::REG_W-1:0]         o_reg_index,
    output logic [bta_pkg::ADDR_W-1:0]        o_address,
    output logic                              o_is_load,
    output logic                              o_access_valid,
    output logic                              o_user_bank_access,
    output logic                              o_loads_pc,
    output logic                              o_restore_status,
    output logic                              o_wb_enable,
    output logic [bta_pkg::REG_W-1:0]         o_wb_register,
    output logic [bta_pkg::ADDR_W-1:0]        o_wb_value,
    output logic                              o_last
);
    import bta_pkg::*;

    `include "assert_macros.svh"

    t_state                r_state, n_state;

    // Latched request
    logic                  r_load;
    logic [ADDR_W-1:0]     r_base;
    logic [REG_W-1:0]      r_bidx;
    logic [NUM_REGS-1:0]   r_list, n_list;
    logic                  r_inc;
    logic                  r_before;
    logic                  r_wben;
    logic                  r_ubank;
    logic                  r_ubank_acc;
    logic [CNT_W-1:0]      r_count;
    logic [ADDR_W-1:0]     r_wbval;
    logic [ADDR_W-1:0]     r_addr;

    // Next values of the output registers
    logic                  n_valid;
    logic [REG_W-1:0]      n_reg_index;
    logic [ADDR_W-1:0]     n_address;
    logic                  n_access_valid;
    logic                  n_user_bank_access;
    logic                  n_loads_pc;
    logic                  n_restore_status;
    logic                  n_wb_enable;
    logic                  n_last;

    logic                  accept;
    t_alu_req              alu_req;
    logic [ADDR_W-1:0]     alu_sum;
    logic [REG_W-1:0]      pick;
    logic [REG_W-1:0]      cur_reg;
    logic                  run_last;
    logic                  cur_lpc;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // Shared adder operand selection
    always_comb begin
        alu_req.sub = !r_inc;
        alu_req.a   = (r_state == ST_RUN) ? r_addr : r_base;
        alu_req.b   = (r_state == ST_WB) ? (ADDR_W'(r_count) << WORD_SHIFT) : WORD_STEP;
    end

    bta_alu u_alu (
        .i_req (alu_req),
        .o_sum (alu_sum)
    );

    // Next register of the walk; descending lists are held bit-reversed
    assign pick     = lowest_set(r_list);
    assign cur_reg  = r_inc ? pick : PC_NUM - pick;
    assign run_last = ((r_list & (r_list - NUM_REGS'(1))) == '0);
    assign cur_lpc  = r_load && (cur_reg == PC_NUM);
    assign n_list   = r_list & (r_list - NUM_REGS'(1));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (start) n_state = ST_WB;
            ST_WB:    n_state = (r_count == '0) ? ST_EMPTY : ST_INIT;
            ST_INIT:  n_state = ST_RUN;
            ST_RUN:   if (run_last) n_state = ST_IDLE;
            ST_EMPTY: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Result fields
    always_comb begin
        n_valid            = 1'b0;
        n_reg_index        = '0;
        n_address          = '0;
        n_access_valid     = 1'b0;
        n_user_bank_access = 1'b0;
        n_loads_pc         = 1'b0;
        n_restore_status   = 1'b0;
        n_wb_enable        = 1'b0;
        n_last             = 1'b0;
        unique case (r_state)
            ST_RUN: begin
                n_valid            = 1'b1;
                n_reg_index        = cur_reg;
                n_address          = r_addr;
                n_access_valid     = 1'b1;
                n_user_bank_access = r_ubank_acc;
                n_loads_pc         = cur_lpc;
                n_restore_status   = cur_lpc && r_ubank;
                n_wb_enable        = run_last && r_wben;
                n_last             = run_last;
            end
            ST_EMPTY: begin
                n_valid     = 1'b1;
                n_wb_enable = r_wben;
                n_last      = 1'b1;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= n_valid;
        end
    end

    // Request latch and datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_load      <= i_req_type;
            r_base      <= i_base_value & ALIGN_MASK;
            r_bidx      <= i_base_index;
            r_list      <= i_increment ? i_register_list : reverse_list(i_register_list);
            r_inc       <= i_increment;
            r_before    <= i_before_req;
            r_ubank     <= i_user_bank;
            r_count     <= CNT_W'($countones(i_register_list));
            r_wben      <= i_user_bank ? (i_req_type && i_writeback && i_register_list[PC_NUM])
                                       : i_writeback;
            r_ubank_acc <= i_user_bank && !(i_req_type && i_register_list[PC_NUM]);
        end
        if (r_state == ST_WB) begin
            r_wbval <= alu_sum;
        end
        if (r_state == ST_INIT) begin
            r_addr <= r_before ? alu_sum : r_base;
        end
        if (r_state == ST_RUN) begin
            r_addr <= alu_sum;
            r_list <= n_list;
        end
    end

    // Output registers
    always_ff @(posedge i_clk) begin
        if (n_valid) begin
            o_reg_index        <= n_reg_index;
            o_address          <= n_address;
            o_is_load          <= r_load;
            o_access_valid     <= n_access_valid;
            o_user_bank_access <= n_user_bank_access;
            o_loads_pc         <= n_loads_pc;
            o_restore_status   <= n_restore_status;
            o_wb_enable        <= n_wb_enable;
            o_wb_register      <= r_bidx;
            o_wb_value         <= r_wbval;
            o_last             <= n_last;
        end
    end

    // Checks
    `ASSERT_IMPL(a_run_has_work, r_state == ST_RUN, r_list != '0, "walk with empty list")
    `ASSERT_IMPL(a_empty_is_last, o_valid && !o_access_valid, o_last,
                 "empty-list result not last")
    `ASSERT_IMPL(a_wb_on_last, o_valid && o_wb_enable, o_last, "writeback before last result")
    `ASSERT_IMPL(a_valid_source, o_valid,
                 $past(r_state) == ST_RUN || $past(r_state) == ST_EMPTY,
                 "result strobe outside issue state")
    `ASSERT_NEXT(a_accept_busy, accept, busy, "request taken but not busy")

endmodule

// ===== sim/bta_result_checker.sv =====
// ----------------------------------------------------------------------------
// Block transfer address sequencer result checker
// Watches the request and result channels of the sequencer, expands every
// accepted request into the accesses it should cause and compares each
// issued result field by field with the oldest outstanding access.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bta_result_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic                          i_req_type,
    input  logic [bta_pkg::ADDR_W-1:0]    i_base_value,
    input  logic [bta_pkg::REG_W-1:0]     i_base_index,
    input  logic [bta_pkg::NUM_REGS-1:0]  i_register_list,
    input  logic                          i_increment,
    input  logic                          i_before_req,
    input  logic                          i_writeback,
    input  logic                          i_user_bank,
    input  logic                          i_valid,
    input  logic [bta_pkg::REG_W-1:0]     i_reg_index,
    input  logic [bta_pkg::ADDR_W-1:0]    i_address,
    input  logic                          i_is_load,
    input  logic                          i_access_valid,
    input  logic                          i_user_bank_access,
    input  logic                          i_loads_pc,
    input  logic                          i_restore_status,
    input  logic                          i_wb_enable,
    input  logic [bta_pkg::REG_W-1:0]     i_wb_register,
    input  logic [bta_pkg::ADDR_W-1:0]    i_wb_value,
    input  logic                          i_last,
    output int                            o_fail_count,
    output int                            o_pending
);

    import bta_pkg::*;

    // One memory access as the sequencer reports it
    typedef struct packed {
        logic [REG_W-1:0]  reg_index;
        logic [ADDR_W-1:0] address;
        logic              is_load;
        logic              access_valid;
        logic              user_bank_access;
        logic              loads_pc;
        logic              restore_status;
        logic              wb_enable;
        logic [REG_W-1:0]  wb_register;
        logic [ADDR_W-1:0] wb_value;
        logic              last;
    } t_access;

    t_access access_due[$];
    int      mismatch_count = 0;

    // Expand one request into its accesses, oldest first
    function automatic void expand_transfer(
        input logic                ld,
        input logic [ADDR_W-1:0]   base_in,
        input logic [REG_W-1:0]    bidx,
        input logic [NUM_REGS-1:0] list,
        input logic                inc,
        input logic                bef,
        input logic                wb,
        input logic                ub
    );
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] span;
        logic [ADDR_W-1:0] addr;
        logic [REG_W-1:0]  r;
        logic              pc_listed;
        logic              wben;
        logic              ubacc;
        int                count;
        int                seen;
        t_access           acc;

        base      = base_in & ALIGN_MASK;
        count     = $countones(list);
        span      = ADDR_W'(count) << WORD_SHIFT;
        pc_listed = list[PC_NUM];
        // user-bank stores never write back; user-bank loads only with the PC
        wben      = ub ? (ld && wb && pc_listed) : wb;
        // exception return takes its registers from the current bank
        ubacc     = ub && !(ld && pc_listed);

        acc             = '0;
        acc.is_load     = ld;
        acc.wb_register = bidx;
        acc.wb_value    = inc ? base + span : base - span;

        if (count == 0) begin
            // empty list: a single result with no access
            acc.wb_enable = wben;
            acc.last      = 1'b1;
            access_due.push_back(acc);
        end else begin
            addr = base;
            if (bef) begin
                addr = inc ? addr + WORD_STEP : addr - WORD_STEP;
            end
            seen = 0;
            for (int k = 0; k < NUM_REGS; k++) begin
                r = inc ? REG_W'(k) : REG_W'(NUM_REGS - 1 - k);
                if (list[r]) begin
                    seen++;
                    acc.reg_index        = r;
                    acc.address          = addr;
                    acc.access_valid     = 1'b1;
                    acc.user_bank_access = ubacc;
                    acc.loads_pc         = ld && (r == PC_NUM);
                    acc.restore_status   = acc.loads_pc && ub;
                    acc.last             = (seen == count);
                    acc.wb_enable        = acc.last && wben;
                    access_due.push_back(acc);
                    addr = inc ? addr + WORD_STEP : addr - WORD_STEP;
                end
            end
        end
    endfunction

    // Report one differing field
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Compare results first, then record a newly accepted request
    always @(posedge i_clk) begin
        t_access want;
        if (i_rst_n) begin
            if (i_valid) begin
                if (access_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with nothing outstanding, expected none, got reg %0h",
                             $time, i_reg_index);
                end else begin
                    want = access_due.pop_front();
                    check_field("reg_index",        32'(want.reg_index),
                                32'(i_reg_index));
                    check_field("address",          want.address,          i_address);
                    check_field("is_load",          32'(want.is_load),     32'(i_is_load));
                    check_field("access_valid",     32'(want.access_valid),
                                32'(i_access_valid));
                    check_field("user_bank_access", 32'(want.user_bank_access),
                                32'(i_user_bank_access));
                    check_field("loads_pc",         32'(want.loads_pc),    32'(i_loads_pc));
                    check_field("restore_status",   32'(want.restore_status),
                                32'(i_restore_status));
                    check_field("wb_enable",        32'(want.wb_enable),   32'(i_wb_enable));
                    check_field("wb_register",      32'(want.wb_register),
                                32'(i_wb_register));
                    check_field("wb_value",         want.wb_value,         i_wb_value);
                    check_field("last",             32'(want.last),        32'(i_last));
                end
            end
            if (i_start && !i_busy) begin
                expand_transfer(i_req_type, i_base_value, i_base_index, i_register_list,
                                i_increment, i_before_req, i_writeback, i_user_bank);
            end
        end
        o_pending    <= access_due.size();
        o_fail_count <= mismatch_count;
    end

endmodule

// ===== sim/block_transfer_address_sequencer_core_tb.sv =====
// ----------------------------------------------------------------------------
// Block transfer address sequencer testbench
// Drives directed and random load/store-multiple requests with random gaps
// into the sequencer; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_transfer_address_sequencer_core_tb;

    import bta_pkg::*;

    localparam int RANDOM_ITEMS = 150;
    localparam int MAX_GAP      = 17;
    localparam int SETTLE       = 25;
    localparam int CYCLE_LIMIT  = 200000;

    // One load/store-multiple request
    typedef struct packed {
        logic                req_type;
        logic [ADDR_W-1:0]   base_value;
        logic [REG_W-1:0]    base_index;
        logic [NUM_REGS-1:0] register_list;
        logic                increment;
        logic                before_req;
        logic                writeback;
        logic                user_bank;
    } t_request;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_req_type;
    logic [ADDR_W-1:0]   i_base_value;
    logic [REG_W-1:0]    i_base_index;
    logic [NUM_REGS-1:0] i_register_list;
    logic                i_increment;
    logic                i_before_req;
    logic                i_writeback;
    logic                i_user_bank;
    logic                o_valid;
    logic [REG_W-1:0]    o_reg_index;
    logic [ADDR_W-1:0]   o_address;
    logic                o_is_load;
    logic                o_access_valid;
    logic                o_user_bank_access;
    logic                o_loads_pc;
    logic                o_restore_status;
    logic                o_wb_enable;
    logic [REG_W-1:0]    o_wb_register;
    logic [ADDR_W-1:0]   o_wb_value;
    logic                o_last;

    int fail_count;
    int pending;
    int cycle_count = 0;

    block_transfer_address_sequencer_core dut (.*);

    bta_result_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_req_type         (i_req_type),
        .i_base_value       (i_base_value),
        .i_base_index       (i_base_index),
        .i_register_list    (i_register_list),
        .i_increment        (i_increment),
        .i_before_req       (i_before_req),
        .i_writeback        (i_writeback),
        .i_user_bank        (i_user_bank),
        .i_valid            (o_valid),
        .i_reg_index        (o_reg_index),
        .i_address          (o_address),
        .i_is_load          (o_is_load),
        .i_access_valid     (o_access_valid),
        .i_user_bank_access (o_user_bank_access),
        .i_loads_pc         (o_loads_pc),
        .i_restore_status   (o_restore_status),
        .i_wb_enable        (o_wb_enable),
        .i_wb_register      (o_wb_register),
        .i_wb_value         (o_wb_value),
        .i_last             (o_last),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("block_transfer_address_sequencer_core test failed");
            $finish;
        end
    end

    // Flags are taken as int so literals and random draws pass unchanged
    function automatic t_request make_request(
        input int ld, input logic [ADDR_W-1:0] base, input logic [REG_W-1:0] bidx,
        input logic [NUM_REGS-1:0] list, input int inc, input int bef,
        input int wb, input int ub
    );
        t_request rq;
        rq.req_type      = 1'(ld);
        rq.base_value    = base;
        rq.base_index    = bidx;
        rq.register_list = list;
        rq.increment     = 1'(inc);
        rq.before_req    = 1'(bef);
        rq.writeback     = 1'(wb);
        rq.user_bank     = 1'(ub);
        return rq;
    endfunction

    // Hold start low for the given gap, then present the item until it is taken.
    // start stays high on acceptance; the next call with a gap, or the end, lowers it.
    task automatic send_request(input t_request rq, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_req_type      <= rq.req_type;
        i_base_value    <= rq.base_value;
        i_base_index    <= rq.base_index;
        i_register_list <= rq.register_list;
        i_increment     <= rq.increment;
        i_before_req    <= rq.before_req;
        i_writeback     <= rq.writeback;
        i_user_bank     <= rq.user_bank;
        do @(posedge i_clk); while (busy);
    endtask

    initial begin
        t_request            rq;
        int                  gap;
        int                  pick;
        logic [NUM_REGS-1:0] list;
        logic [ADDR_W-1:0]   base;

        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_req_type      <= 1'b0;
        i_base_value    <= '0;
        i_base_index    <= '0;
        i_register_list <= '0;
        i_increment     <= 1'b0;
        i_before_req    <= 1'b0;
        i_writeback     <= 1'b0;
        i_user_bank     <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty lists, full lists with address wrap, exception
        // return, user-bank forms, PC load and store, base in the list
        send_request(make_request(0, 32'h0000_1003, 4'd2,  16'h0000, 1, 0, 1, 0),
                     $urandom_range(0, MAX_GAP));
        send_request(make_request(1, 32'hFFFF_FFFF, 4'd15, 16'h0000, 0, 1, 1, 1),
                     $urandom_range(0, MAX_GAP));
        send_request(make_request(1, 32'hFFFF_FFFF, 4'd13, 16'hFFFF, 1, 1, 1, 0), 0);
        send_request(make_request(0, 32'h0000_0002, 4'd0,  16'hFFFF, 0, 1, 1, 0), 0);
        send_request(make_request(1, 32'h8000_0010, 4'd13, 16'h8001, 1, 0, 1, 1),
                     $urandom_range(0, MAX_GAP));
        send_request(make_request(1, 32'h8000_0010, 4'd13, 16'h8000, 0, 1, 0, 1),
                     $urandom_range(0, MAX_GAP));
        send_request(make_request(0, 32'h2000_0000, 4'd1,  16'h0001, 1, 1, 1, 1),
                     $urandom_range(0, MAX_GAP));
        send_request(make_request(1, 32'h2000_0004, 4'd1,  16'h00F0, 0, 0, 1, 1), 0);
        send_request(make_request(1, 32'h4000_0000, 4'd4,  16'hC000, 1, 0, 1, 0),
                     $urandom_range(0, MAX_GAP));
        send_request(make_request(0, 32'h4000_0000, 4'd4,  16'h8000, 0, 0, 0, 0), 0);
        send_request(make_request(1, 32'h1234_5678, 4'd3,  16'h0018, 1, 1, 1, 0),
                     $urandom_range(0, MAX_GAP));
        send_request(make_request(0, 32'hFFFF_FFFC, 4'd15, 16'h5A5A, 1, 0, 1, 0),
                     $urandom_range(0, MAX_GAP));
        send_request(make_request(1, 32'h0000_0004, 4'd0,  16'hA5A5, 0, 0, 1, 0), 0);
        send_request(make_request(0, 32'h0000_0000, 4'd14, 16'hFFFF, 1, 0, 0, 1),
                     $urandom_range(0, MAX_GAP));
        send_request(make_request(1, 32'hFFFF_FFFC, 4'd7,  16'hFFFF, 0, 0, 1, 1),
                     $urandom_range(0, MAX_GAP));
        send_request(make_request(0, 32'h7FFF_FFFE, 4'd8,  16'h0001, 0, 1, 0, 0),
                     $urandom_range(0, MAX_GAP));

        // Random: list shapes weighted towards the corners, bases near the
        // wrap points, and every third stretch of 20 items back to back
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: begin
                    list = '0;
                end
                1: begin
                    list = '1;
                end
                2: begin
                    list = NUM_REGS'(1) << $urandom_range(0, NUM_REGS - 1);
                end
                3: begin
                    list = NUM_REGS'($urandom) | (NUM_REGS'(1) << PC_NUM);
                end
                default: begin
                    list = NUM_REGS'($urandom);
                end
            endcase
            pick = $urandom_range(0, 5);
            if (pick == 0) begin
                base = ADDR_W'($urandom_range(0, 15));
            end else if (pick == 1) begin
                base = ~ADDR_W'($urandom_range(0, 15));
            end else begin
                base = $urandom;
            end
            rq = make_request($urandom_range(0, 1), base, REG_W'($urandom_range(0, 15)),
                              list, $urandom_range(0, 1), $urandom_range(0, 1),
                              $urandom_range(0, 1), $urandom_range(0, 1));
            gap = ((n / 20) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
            send_request(rq, gap);
        end
        start <= 1'b0;

        // Drain outstanding results, then let the block settle
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("block_transfer_address_sequencer_core test passed");
        end else begin
            $display("block_transfer_address_sequencer_core test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/bta_pkg.sv
design/bta_alu.sv
design/block_transfer_address_sequencer_core.sv
sim/bta_result_checker.sv
sim/block_transfer_address_sequencer_core_tb.sv
